// ===== rtl/edf_pkg.sv =====
// Package for the EDF tick scheduler: payload structs, table entry and
// write-port types, command codes and sizing constants.
// No dependencies; used by every module of the block by scoped names.
package edf_pkg;

    // Table depth and derived index width
    localparam int MAX_TASKS = 8;
    localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    // Field widths fixed by the interface
    localparam int CNT_W  = 4;
    localparam int TIDX_W = 3;
    localparam int VAL_W  = 16;
    localparam int TIME_W = 32;
    localparam int RUN_W  = 4;

    // Commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic              command;
        logic [TIDX_W-1:0] task_index;
        logic [VAL_W-1:0]  task_period;
        logic [VAL_W-1:0]  task_exec;
        logic [VAL_W-1:0]  task_deadline;
    } t_in_item;

    typedef struct packed {
        logic [TIME_W-1:0] slot_time;
        logic [RUN_W-1:0]  running_task;
    } t_out_item;

    // One task entry; phase holds current time modulo the period
    typedef struct packed {
        logic [VAL_W-1:0]  period;
        logic [VAL_W-1:0]  exec;
        logic [VAL_W-1:0]  reld;
        logic [VAL_W-1:0]  rw;
        logic [TIME_W-1:0] ad;
        logic [VAL_W-1:0]  ph;
    } t_entry;

    // Write command into the task table
    typedef struct packed {
        logic   wr_cfg;
        logic   wr_rw;
        logic   wr_ad;
        logic   wr_ph;
        logic   clr_ph;
        t_idx   addr;
        t_entry data;
    } t_tbl_wr;

    // Result of evaluating one entry in the sweep
    typedef struct packed {
        logic              rel;
        logic              take;
        logic [VAL_W-1:0]  new_rw;
        logic [TIME_W-1:0] new_ad;
        logic [VAL_W-1:0]  new_ph;
    } t_eval;

endpackage

// ===== rtl/edf_eval_unit.sv =====
// Shared per-entry evaluation unit: release check, saturating deadline add,
// phase advance and earliest-deadline compare. Depends on edf_pkg.
module edf_eval_unit (
    input  edf_pkg::t_entry                i_entry,
    input  logic [edf_pkg::TIME_W-1:0]     i_time,
    input  logic                           i_active,
    input  logic                           i_found,
    input  logic [edf_pkg::TIME_W-1:0]     i_best_d,
    output edf_pkg::t_eval                 o_eval
);

    logic [edf_pkg::TIME_W:0]  w_sum;
    logic [edf_pkg::VAL_W-1:0] w_ph_inc;
    logic                      w_rel;
    logic [edf_pkg::VAL_W-1:0] w_rw;
    logic [edf_pkg::TIME_W-1:0] w_ad;

    // Release when time is non-zero and a multiple of a non-zero period
    assign w_rel = (i_time != '0) && (i_entry.period != '0) && (i_entry.ph == '0);

    // Saturating absolute deadline
    assign w_sum = {1'b0, i_time} + (edf_pkg::TIME_W+1)'(i_entry.reld);

    always_comb begin
        if (w_rel) begin
            w_rw = i_entry.exec;
            w_ad = w_sum[edf_pkg::TIME_W] ? '1 : w_sum[edf_pkg::TIME_W-1:0];
        end else begin
            w_rw = i_entry.rw;
            w_ad = i_entry.ad;
        end
    end

    // Advance the phase, wrapping at the period
    assign w_ph_inc = i_entry.ph + edf_pkg::VAL_W'(1);

    always_comb begin
        o_eval.rel    = w_rel;
        o_eval.new_rw = w_rw;
        o_eval.new_ad = w_ad;
        o_eval.new_ph = (w_ph_inc == i_entry.period) ? '0 : w_ph_inc;
        o_eval.take   = i_active && (w_rw != '0) && (!i_found || (w_ad < i_best_d));
    end

endmodule

// ===== rtl/edf_task_table.sv =====
// Task table: per-entry period, execution time, relative deadline,
// remaining work, absolute deadline and phase. Depends on edf_pkg.
module edf_task_table (
    input  logic             i_clk,
    input  edf_pkg::t_tbl_wr i_wr,
    input  edf_pkg::t_idx    i_raddr,
    output edf_pkg::t_entry  o_rdata
);

    edf_pkg::t_entry r_mem [edf_pkg::MAX_TASKS];

    // Write selected fields; clear every phase on a load
    always_ff @(posedge i_clk) begin
        if (i_wr.wr_cfg) begin
            r_mem[i_wr.addr].period <= i_wr.data.period;
            r_mem[i_wr.addr].exec   <= i_wr.data.exec;
            r_mem[i_wr.addr].reld   <= i_wr.data.reld;
        end
        if (i_wr.wr_rw) begin
            r_mem[i_wr.addr].rw <= i_wr.data.rw;
        end
        if (i_wr.wr_ad) begin
            r_mem[i_wr.addr].ad <= i_wr.data.ad;
        end
        if (i_wr.clr_ph) begin
            for (int i = 0; i < edf_pkg::MAX_TASKS; i++) begin
                r_mem[i].ph <= '0;
            end
        end else if (i_wr.wr_ph) begin
            r_mem[i_wr.addr].ph <= i_wr.data.ph;
        end
    end

    // Single read port at the sweep address
    assign o_rdata = r_mem[i_raddr];

endmodule

// ===== rtl/edf_tick_scheduler_unit.sv =====
// Earliest-deadline-first periodic tick scheduler, top level.
// Depends on edf_pkg, edf_eval_unit and edf_task_table.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries load and
//   tick transactions. A load writes one task entry, releases it and sets
//   time back to 0; it gives no result.
//   A tick sweeps every table entry through the shared evaluation unit,
//   one entry per cycle, then forms the slot decision in the done state,
//   which waits for a free output register; the next transaction is taken
//   only once the tick has left that state and the sequencer is idle.
//   Output channel (o_out_valid / i_out_ready / o_out_data) gives slot time
//   and running task (index plus one, 0 when idle). The result sits in an
//   output register; if it is still waiting when the next tick finishes its
//   sweep, that tick holds until the register frees.
//   Configuration: i_cfg_we writes task_count from i_cfg_wdata at once.
//   Reset (synchronous, active low) clears time, task_count and the output
//   valid; table contents are undefined until loaded.
module edf_tick_scheduler_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [edf_pkg::CNT_W-1:0]   i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  edf_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output edf_pkg::t_out_item          o_out_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    logic [1:0]                  r_state, n_state;
    edf_pkg::t_idx               r_idx, n_idx;
    logic [edf_pkg::TIME_W-1:0]  r_time, n_time;
    logic [edf_pkg::CNT_W-1:0]   r_task_count, n_task_count;
    logic                        r_found, n_found;
    edf_pkg::t_idx               r_sel, n_sel;
    logic [edf_pkg::TIME_W-1:0]  r_best_d, n_best_d;
    logic [edf_pkg::VAL_W-1:0]   r_sel_rw, n_sel_rw;
    logic                        r_out_valid, n_out_valid;
    edf_pkg::t_out_item          r_out_data, n_out_data;

    edf_pkg::t_tbl_wr            w_wr;
    edf_pkg::t_entry             w_entry;
    edf_pkg::t_eval              w_eval;
    logic                        w_in_acc;
    logic                        w_active;
    logic                        w_last;
    logic                        w_time_max;
    logic                        w_done_fire;
    logic                        w_load_ok;
    logic [31:0]                 w_run;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_active    = (32'(r_idx) < 32'(r_task_count));
    assign w_last      = (r_idx == edf_pkg::IDX_W'(edf_pkg::MAX_TASKS - 1));
    assign w_time_max  = (r_time == '1);
    assign w_done_fire = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);
    assign w_load_ok   = (32'(i_in_data.task_index) < edf_pkg::MAX_TASKS);
    assign w_run       = 32'(r_sel) + 32'd1;

    edf_task_table u_table (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_raddr (r_idx),
        .o_rdata (w_entry)
    );

    edf_eval_unit u_eval (
        .i_entry  (w_entry),
        .i_time   (r_time),
        .i_active (w_active),
        .i_found  (r_found),
        .i_best_d (r_best_d),
        .o_eval   (w_eval)
    );

    // Table write: load, sweep write-back, or decrement of the chosen task
    always_comb begin
        w_wr             = '0;
        w_wr.data.period = i_in_data.task_period;
        w_wr.data.exec   = i_in_data.task_exec;
        w_wr.data.reld   = i_in_data.task_deadline;
        w_wr.data.ph     = w_eval.new_ph;
        w_wr.data.rw     = w_eval.new_rw;
        w_wr.data.ad     = w_eval.new_ad;
        w_wr.addr        = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (i_in_data.command == edf_pkg::CMD_LOAD) && w_load_ok) begin
                    w_wr.addr    = edf_pkg::IDX_W'(i_in_data.task_index);
                    w_wr.wr_cfg  = 1'b1;
                    w_wr.wr_rw   = 1'b1;
                    w_wr.wr_ad   = 1'b1;
                    w_wr.clr_ph  = 1'b1;
                    w_wr.data.rw = i_in_data.task_exec;
                    w_wr.data.ad = edf_pkg::TIME_W'(i_in_data.task_deadline);
                end
            end
            ST_SWEEP: begin
                w_wr.wr_rw = w_active && w_eval.rel;
                w_wr.wr_ad = w_active && w_eval.rel;
                w_wr.wr_ph = !w_time_max;
            end
            ST_DONE: begin
                w_wr.addr    = r_sel;
                w_wr.wr_rw   = w_done_fire && r_found;
                w_wr.data.rw = r_sel_rw - edf_pkg::VAL_W'(1);
            end
            default: begin
                w_wr.addr = r_idx;
            end
        endcase
    end

    // Sequencer next state
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_time       = r_time;
        n_task_count = i_cfg_we ? i_cfg_wdata : r_task_count;
        n_found      = r_found;
        n_sel        = r_sel;
        n_best_d     = r_best_d;
        n_sel_rw     = r_sel_rw;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_data   = r_out_data;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_in_data.command == edf_pkg::CMD_TICK) begin
                        n_state = ST_SWEEP;
                        n_idx   = '0;
                        n_found = 1'b0;
                    end else if (w_load_ok) begin
                        n_time = '0;
                    end
                end
            end
            ST_SWEEP: begin
                if (w_eval.take) begin
                    n_found  = 1'b1;
                    n_best_d = w_eval.new_ad;
                    n_sel    = r_idx;
                    n_sel_rw = w_eval.new_rw;
                end
                if (w_last) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + edf_pkg::IDX_W'(1);
                end
            end
            ST_DONE: begin
                if (w_done_fire) begin
                    n_out_valid             = 1'b1;
                    n_out_data.slot_time    = r_time;
                    n_out_data.running_task = r_found ? w_run[edf_pkg::RUN_W-1:0] : '0;
                    if (!w_time_max) begin
                        n_time = r_time + edf_pkg::TIME_W'(1);
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_time       <= '0;
            r_task_count <= '0;
            r_found      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_time       <= n_time;
            r_task_count <= n_task_count;
            r_found      <= n_found;
            r_out_valid  <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_sel      <= n_sel;
        r_best_d   <= n_best_d;
        r_sel_rw   <= n_sel_rw;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== test/edf_tick_scheduler_unit_tb.sv =====
// Testbench for edf_tick_scheduler_unit: load and tick transactions with random idling
// on both channels, every slot decision checked against a behavioural EDF predictor.
// Depends on edf_pkg and the edf_tick_scheduler_unit RTL.
module edf_tick_scheduler_unit_tb;
    import edf_pkg::*;

    localparam int TOTAL_ITEMS   = 550;
    localparam int SETTLE_CYCLES = MAX_TASKS + 6;
    localparam int QUIET_LIMIT   = 2000;

    // Predicts the slot decision of every tick and holds the decisions still owed
    class edf_slot_scoreboard;
        bit [VAL_W-1:0]  period_tbl [MAX_TASKS];
        bit [VAL_W-1:0]  exec_tbl   [MAX_TASKS];
        bit [VAL_W-1:0]  reld_tbl   [MAX_TASKS];
        bit [VAL_W-1:0]  rem_work   [MAX_TASKS];
        bit [TIME_W-1:0] abs_dl     [MAX_TASKS];
        bit [TIME_W-1:0] now_tick;
        bit [CNT_W-1:0]  task_count;
        t_out_item       expected_slots [$];
        int unsigned     mismatches;

        function void set_task_count(input bit [CNT_W-1:0] value);
            task_count = value;
        endfunction

        // Apply one accepted transaction; a tick queues the slot it decides
        function void note_transaction(input t_in_item item);
            int            n;
            int            sel;
            bit            found;
            bit [TIME_W-1:0] best;
            bit [TIME_W:0] sum;
            t_out_item     slot;
            if (item.command == CMD_LOAD) begin
                period_tbl[item.task_index] = item.task_period;
                exec_tbl[item.task_index]   = item.task_exec;
                reld_tbl[item.task_index]   = item.task_deadline;
                rem_work[item.task_index]   = item.task_exec;
                abs_dl[item.task_index]     = TIME_W'(item.task_deadline);
                now_tick = '0;
            end else begin
                n = (task_count > MAX_TASKS) ? MAX_TASKS : int'(task_count);
                // re-release every task whose period divides the current time
                for (int i = 0; i < n; i++) begin
                    if (now_tick != 0 && period_tbl[i] != 0 &&
                        (now_tick % TIME_W'(period_tbl[i])) == 0) begin
                        rem_work[i] = exec_tbl[i];
                        sum = {1'b0, now_tick} + (TIME_W+1)'(reld_tbl[i]);
                        abs_dl[i] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                    end
                end
                // earliest deadline with work left, lowest index on a tie
                found = 1'b0;
                sel   = 0;
                best  = '0;
                for (int i = 0; i < n; i++) begin
                    if (rem_work[i] != 0 && (!found || abs_dl[i] < best)) begin
                        found = 1'b1;
                        best  = abs_dl[i];
                        sel   = i;
                    end
                end
                slot.slot_time    = now_tick;
                slot.running_task = found ? RUN_W'(sel + 1) : '0;
                if (found) rem_work[sel] = rem_work[sel] - VAL_W'(1);
                if (now_tick != '1) now_tick = now_tick + TIME_W'(1);
                expected_slots.push_back(slot);
            end
        endfunction

        // Compare one accepted slot with the oldest decision owed
        function void check_slot(input t_out_item got);
            t_out_item want;
            if (expected_slots.size() == 0) begin
                $display("%0t: slot result with none expected, got time %0d task %0d",
                         $time, got.slot_time, got.running_task);
                mismatches++;
            end else begin
                want = expected_slots.pop_front();
                if (got.slot_time !== want.slot_time) begin
                    $display("%0t: slot_time expected %0d got %0d",
                             $time, want.slot_time, got.slot_time);
                    mismatches++;
                end
                if (got.running_task !== want.running_task) begin
                    $display("%0t: running_task expected %0d got %0d at slot %0d",
                             $time, want.running_task, got.running_task, want.slot_time);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [CNT_W-1:0]   i_cfg_wdata = '0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    t_in_item           i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_out_item          o_out_data;

    edf_slot_scoreboard sb = new;
    bit                 calm = 1'b0;
    int unsigned        sent_items = 0;
    int unsigned        quiet_cycles = 0;

    edf_tick_scheduler_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Take slot results and throttle the output side
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_slot(o_out_data);
        end
        i_out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 33);
    end

    // Abort when no transaction moves on either channel for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [VAL_W-1:0] rand_val(input int unsigned small_max);
        if ($urandom_range(9) == 0) begin
            return VAL_W'($urandom);
        end
        return VAL_W'($urandom_range(small_max));
    endfunction

    function automatic t_in_item load_item(input logic [TIDX_W-1:0] idx,
                                           input logic [VAL_W-1:0] period,
                                           input logic [VAL_W-1:0] exec_ticks,
                                           input logic [VAL_W-1:0] deadline);
        t_in_item it;
        it.command       = CMD_LOAD;
        it.task_index    = idx;
        it.task_period   = period;
        it.task_exec     = exec_ticks;
        it.task_deadline = deadline;
        return it;
    endfunction

    // Tick with random content in the unused fields
    function automatic t_in_item tick_item();
        t_in_item it;
        it.command       = CMD_TICK;
        it.task_index    = TIDX_W'($urandom);
        it.task_period   = VAL_W'($urandom);
        it.task_exec     = VAL_W'($urandom);
        it.task_deadline = VAL_W'($urandom);
        return it;
    endfunction

    // Offer one transaction, idling first at random, and hold it until accepted
    task automatic send_transaction(input t_in_item item);
        if (!calm && $urandom_range(99) < 33) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 33);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_transaction(item);
        sent_items++;
        calm = (sent_items >= 200 && sent_items < 320);
    endtask

    // Stop sending until every slot has come back and a load has surely finished
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        while (sb.expected_slots.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_task_count(input logic [CNT_W-1:0] value);
        hold_until_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.set_task_count(value);
        i_cfg_we    <= 1'b0;
    endtask

    // Load a random group of tasks, then run ticks with the odd stray load
    task automatic run_task_set();
        int unsigned      loads;
        int unsigned      ticks;
        logic [VAL_W-1:0] period;
        loads = $urandom_range(1, MAX_TASKS);
        for (int k = 0; k < loads; k++) begin
            period = rand_val(16);
            send_transaction(load_item(TIDX_W'($urandom_range(MAX_TASKS - 1)), period,
                                       rand_val(4), rand_val(24)));
        end
        ticks = $urandom_range(8, 48);
        for (int k = 0; k < ticks; k++) begin
            if ($urandom_range(29) == 0) begin
                send_transaction(load_item(TIDX_W'($urandom), rand_val(16),
                                           rand_val(4), rand_val(24)));
            end else begin
                send_transaction(tick_item());
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no active entries: ticks stay idle
        write_task_count('0);
        send_transaction(tick_item());
        send_transaction(tick_item());

        // fill every entry: zero work, extremes, zero period, deadline ties
        send_transaction(load_item(3'd0, 16'd1, 16'd0, 16'd0));
        send_transaction(load_item(3'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_transaction(load_item(3'd2, 16'd0, 16'd3, 16'd2));
        send_transaction(load_item(3'd3, 16'd4, 16'd1, 16'd0));
        send_transaction(load_item(3'd4, 16'd5, 16'd2, 16'd2));
        send_transaction(load_item(3'd5, 16'd6, 16'd1, 16'd2));
        send_transaction(load_item(3'd6, 16'd3, 16'd1, 16'd7));
        send_transaction(load_item(3'd7, 16'h5555, 16'd2, 16'hAAAA));

        write_task_count(CNT_W'(MAX_TASKS));
        repeat (10) send_transaction(tick_item());
        // a load part-way through sends time back to zero
        send_transaction(load_item(3'd3, 16'd2, 16'd1, 16'd1));

        // count above the table size acts as the full table
        write_task_count('1);
        repeat (3) send_transaction(tick_item());

        // random task sets under changing counts
        while (sent_items < TOTAL_ITEMS) begin
            case ($urandom_range(7))
                0: write_task_count('0);
                1: write_task_count('1);
                2: write_task_count(CNT_W'($urandom_range(15)));
                3: write_task_count(CNT_W'(MAX_TASKS));
                4: hold_until_drained();
                default: ;
            endcase
            run_task_set();
        end

        i_in_valid <= 1'b0;
        while (sb.expected_slots.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_slots.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
